@@ sv/nand_bus_cycle_grouper_unit_macros.svh @@
// assertion macros for the nand bus cycle grouper
`ifndef NAND_BUS_CYCLE_GROUPER_UNIT_MACROS_SVH
`define NAND_BUS_CYCLE_GROUPER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NBCG_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("nbcg assertion failed");
`define NBCG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nbcg assertion failed");
`else
`define NBCG_ASSERT(lbl, cond)
`define NBCG_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ sv/nbcg_pkg.sv @@
// types, codes and decode functions of the nand bus cycle grouper
`default_nettype none
package nbcg_pkg;

    localparam int MAX_RES = 8;

    localparam logic [3:0] EV_UNKNOWN  = 4'd0;
    localparam logic [3:0] EV_READ_ID  = 4'd1;
    localparam logic [3:0] EV_VSTART   = 4'd2;
    localparam logic [3:0] EV_RESET    = 4'd3;
    localparam logic [3:0] EV_VPARAM   = 4'd4;
    localparam logic [3:0] EV_STATUS   = 4'd5;
    localparam logic [3:0] EV_PARPAGE  = 4'd6;
    localparam logic [3:0] EV_CHARGE1  = 4'd7;
    localparam logic [3:0] EV_CHARGE2  = 4'd8;
    localparam logic [3:0] EV_CHG_COL  = 4'd9;
    localparam logic [3:0] EV_READ     = 4'd10;
    localparam logic [3:0] EV_CACHE_30 = 4'd11;
    localparam logic [3:0] EV_CACHE_A2 = 4'd12;
    localparam logic [3:0] EV_CACHE_69 = 4'd13;
    localparam logic [3:0] EV_CACHE_FD = 4'd14;

    localparam logic [2:0] PT_START = 3'd0;
    localparam logic [2:0] PT_ADDR  = 3'd1;
    localparam logic [2:0] PT_DATA  = 3'd2;
    localparam logic [2:0] PT_END   = 3'd3;
    localparam logic [2:0] PT_RAW   = 3'd4;

    localparam logic [7:0] OP_READ_ID  = 8'h90;
    localparam logic [7:0] OP_VSTART   = 8'h5c;
    localparam logic [7:0] OP_VSTART2  = 8'hc5;
    localparam logic [7:0] OP_RESET    = 8'hff;
    localparam logic [7:0] OP_VPARAM   = 8'h55;
    localparam logic [7:0] OP_STATUS   = 8'h70;
    localparam logic [7:0] OP_PARPAGE  = 8'hec;
    localparam logic [7:0] OP_CHARGE1  = 8'h65;
    localparam logic [7:0] OP_CHARGE2  = 8'h60;
    localparam logic [7:0] OP_CHG_COL  = 8'h05;
    localparam logic [7:0] OP_CHG_CONF = 8'he0;
    localparam logic [7:0] OP_READ     = 8'h00;
    localparam logic [7:0] OP_READ_CNF = 8'h30;
    localparam logic [7:0] OP_CACHE_A2 = 8'ha2;
    localparam logic [7:0] OP_CACHE_69 = 8'h69;
    localparam logic [7:0] OP_CACHE_FD = 8'hfd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SHAPE,
        PH_ID_ADDR,
        PH_ID_DATA,
        PH_RUN
    } t_phase;

    typedef struct packed {
        logic [3:0]  code;
        logic [2:0]  part;
        logic [7:0]  byte_value;
        logic [13:0] byte_index;
        logic [3:0]  ctl;
        logic [7:0]  aux;
        logic [61:0] stamp;
        logic        last;
    } t_res;

    function automatic t_res f_put(logic [3:0] code, logic [2:0] part, logic [7:0] b,
                                   logic [13:0] idx, logic [3:0] ctl, logic [7:0] aux,
                                   logic [61:0] t, logic last);
        t_res r;
        r.code = code;
        r.part = part;
        r.byte_value = b;
        r.byte_index = idx;
        r.ctl = ctl;
        r.aux = aux;
        r.stamp = t;
        r.last = last;
        return r;
    endfunction

    function automatic t_res f_raw(logic [19:0] c, logic [61:0] t, logic last);
        return f_put(EV_UNKNOWN, PT_RAW, c[7:0], 14'd0, c[11:8], c[19:12], t, last);
    endfunction

    function automatic t_res f_byte(logic [3:0] code, logic [2:0] part, logic [19:0] c,
                                    logic [61:0] t, logic [13:0] idx);
        return f_put(code, part, c[7:0], idx, 4'd0, c[19:12], t, 1'b0);
    endfunction

    function automatic t_res f_start(logic [3:0] code, logic [19:0] c, logic [61:0] t);
        return f_put(code, PT_START, c[7:0], 14'd0, 4'd0, c[19:12], t, 1'b0);
    endfunction

    function automatic t_res f_end(logic [3:0] code, logic [13:0] cnt, logic [19:0] c,
                                   logic [61:0] t);
        return f_put(code, PT_END, 8'd0, cnt, 4'd0, c[19:12], t, 1'b1);
    endfunction

    function automatic logic [3:0] f_cmd_code(logic [7:0] b);
        logic [3:0] r;
        unique case (b)
            OP_READ_ID:  r = EV_READ_ID;
            OP_VSTART:   r = EV_VSTART;
            OP_RESET:    r = EV_RESET;
            OP_VPARAM:   r = EV_VPARAM;
            OP_STATUS:   r = EV_STATUS;
            OP_PARPAGE:  r = EV_PARPAGE;
            OP_CHARGE1:  r = EV_CHARGE1;
            OP_CHARGE2:  r = EV_CHARGE2;
            OP_CHG_COL:  r = EV_CHG_COL;
            OP_READ:     r = EV_READ;
            OP_READ_CNF: r = EV_CACHE_30;
            OP_CACHE_A2: r = EV_CACHE_A2;
            OP_CACHE_69: r = EV_CACHE_69;
            OP_CACHE_FD: r = EV_CACHE_FD;
            default:     r = EV_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] f_shape_len(logic [3:0] code);
        logic [2:0] r;
        case (code) inside
            EV_VSTART, EV_RESET, EV_STATUS, EV_PARPAGE: r = 3'd2;
            EV_VPARAM:                                  r = 3'd3;
            EV_CHARGE1, EV_CHARGE2:                     r = 3'd4;
            EV_CHG_COL, EV_READ:                        r = 3'd7;
            default:                                    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic f_shape_ok(logic [3:0] code, logic [2:0] k, logic [19:0] c);
        logic cle;
        logic ale;
        logic we;
        logic re;
        logic addr;
        logic r;
        cle = c[8];
        ale = c[9];
        we = c[10];
        re = c[11];
        addr = ale && !cle && we;
        case (code) inside
            EV_VSTART: r = cle && (c[7:0] == OP_VSTART2);
            EV_RESET:  r = cle && (c[7:0] == OP_READ);
            EV_VPARAM: r = (k == 3'd1) ? (ale || we) : (!ale && !cle && !re);
            EV_STATUS: r = !ale && !cle && !we;
            EV_PARPAGE, EV_CHARGE1, EV_CHARGE2: r = addr;
            EV_CHG_COL, EV_READ: begin
                if (k <= 3'd5) begin
                    r = addr;
                end else begin
                    r = !ale && cle && we &&
                        (c[7:0] == ((code == EV_CHG_COL) ? OP_CHG_CONF : OP_READ_CNF));
                end
            end
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/nbcg_ctrl.sv @@
// command state machine and held cycles, builds the results of one bus cycle
`default_nettype none
module nbcg_ctrl #(
    parameter int ID_MAX = 8,
    parameter int DATA_MAX = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [19:0]        i_cycle,
    input  wire logic [61:0]        i_stamp,
    output nbcg_pkg::t_res          o_res [nbcg_pkg::MAX_RES],
    output logic [3:0]              o_cnt
);
    localparam int CW = $clog2(DATA_MAX + 1);

    nbcg_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_pend, n_pend;
    logic [2:0]       r_step, n_step;
    logic [CW-1:0]    r_dcnt, n_dcnt;
    logic [19:0]      r_hcyc [7];
    logic [61:0]      r_htim [7];

    logic             hw_en;
    logic [2:0]       hw_idx;
    logic             do_idle;
    logic [3:0]       n;
    logic [3:0]       code;
    logic [3:0]       ncode;
    logic [2:0]       k;
    logic [2:0]       slen;
    logic             re;
    logic [CW-1:0]    dinc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nbcg_pkg::PH_IDLE;
            r_pend <= 4'd0;
            r_step <= 3'd0;
            r_dcnt <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pend <= n_pend;
            r_step <= n_step;
            r_dcnt <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && hw_en) begin
            r_hcyc[hw_idx] <= i_cycle;
            r_htim[hw_idx] <= i_stamp;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pend = r_pend;
        n_step = r_step;
        n_dcnt = r_dcnt;
        hw_en = 1'b0;
        hw_idx = 3'd0;
        do_idle = 1'b0;
        n = 4'd0;
        for (int i = 0; i < nbcg_pkg::MAX_RES; i++) begin
            o_res[i] = '0;
        end
        code = r_pend;
        k = r_step;
        slen = nbcg_pkg::f_shape_len(code);
        re = i_cycle[11];
        dinc = r_dcnt + CW'(1);
        ncode = nbcg_pkg::f_cmd_code(i_cycle[7:0]);
        unique case (r_phase)
            nbcg_pkg::PH_SHAPE: begin
                if (k == 3'd0 || k == 3'd7 || slen == 3'd0 || k >= slen) begin
                    do_idle = 1'b1;
                end else if (!nbcg_pkg::f_shape_ok(code, k, i_cycle)) begin
                    for (int i = 0; i < 7; i++) begin
                        if (3'(i) < k) begin
                            o_res[i] = nbcg_pkg::f_raw(r_hcyc[i], r_htim[i], 1'b0);
                        end
                    end
                    o_res[k] = nbcg_pkg::f_raw(i_cycle, i_stamp, 1'b1);
                    n = {1'b0, k} + 4'd1;
                    n_phase = nbcg_pkg::PH_IDLE;
                end else if (k + 3'd1 < slen) begin
                    hw_en = 1'b1;
                    hw_idx = k;
                    n_step = k + 3'd1;
                end else begin
                    n_phase = nbcg_pkg::PH_IDLE;
                    o_res[0] = nbcg_pkg::f_start(code, r_hcyc[0], r_htim[0]);
                    unique case (code) inside
                        nbcg_pkg::EV_VPARAM: begin
                            o_res[1] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR, r_hcyc[1],
                                                        r_htim[1], 14'd0);
                            o_res[2] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_DATA, i_cycle,
                                                        i_stamp, 14'd0);
                            o_res[3] = nbcg_pkg::f_end(code, 14'd1, i_cycle, i_stamp);
                            n = 4'd4;
                        end
                        nbcg_pkg::EV_STATUS: begin
                            o_res[1] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_DATA, i_cycle,
                                                        i_stamp, 14'd0);
                            o_res[2] = nbcg_pkg::f_end(code, 14'd1, i_cycle, i_stamp);
                            n = 4'd3;
                        end
                        nbcg_pkg::EV_PARPAGE: begin
                            o_res[1] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR, i_cycle,
                                                        i_stamp, 14'd0);
                            hw_en = 1'b1;
                            hw_idx = 3'd6;
                            n_dcnt = '0;
                            n_phase = nbcg_pkg::PH_RUN;
                            n = 4'd2;
                        end
                        nbcg_pkg::EV_CHARGE1, nbcg_pkg::EV_CHARGE2: begin
                            o_res[1] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR, r_hcyc[1],
                                                        r_htim[1], 14'd0);
                            o_res[2] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR, r_hcyc[2],
                                                        r_htim[2], 14'd1);
                            o_res[3] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR, i_cycle,
                                                        i_stamp, 14'd2);
                            o_res[4] = nbcg_pkg::f_end(code, 14'd0, i_cycle, i_stamp);
                            n = 4'd5;
                        end
                        nbcg_pkg::EV_CHG_COL, nbcg_pkg::EV_READ: begin
                            for (int i = 1; i <= 5; i++) begin
                                o_res[i] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_ADDR,
                                                            r_hcyc[i], r_htim[i], 14'(i - 1));
                            end
                            hw_en = 1'b1;
                            hw_idx = 3'd6;
                            n_dcnt = '0;
                            n_phase = nbcg_pkg::PH_RUN;
                            n = 4'd6;
                        end
                        default: begin
                            o_res[1] = nbcg_pkg::f_end(code, 14'd0, i_cycle, i_stamp);
                            n = 4'd2;
                        end
                    endcase
                end
            end
            nbcg_pkg::PH_RUN: begin
                if (re) begin
                    o_res[0] = nbcg_pkg::f_byte(code, nbcg_pkg::PT_DATA, i_cycle, i_stamp,
                                                14'(r_dcnt));
                    n_dcnt = dinc;
                    hw_en = 1'b1;
                    hw_idx = 3'd6;
                    n = 4'd1;
                    if (dinc >= CW'(DATA_MAX)) begin
                        n_phase = nbcg_pkg::PH_IDLE;
                        o_res[1] = nbcg_pkg::f_end(code, 14'(dinc), i_cycle, i_stamp);
                        n = 4'd2;
                    end
                end else begin
                    o_res[0] = nbcg_pkg::f_end(code, 14'(r_dcnt), r_hcyc[6], r_htim[6]);
                    n = 4'd1;
                    do_idle = 1'b1;
                end
            end
            nbcg_pkg::PH_ID_ADDR: begin
                o_res[0] = nbcg_pkg::f_byte(nbcg_pkg::EV_READ_ID, nbcg_pkg::PT_ADDR,
                                            i_cycle, i_stamp, 14'd0);
                n = 4'd1;
                hw_en = 1'b1;
                hw_idx = 3'd6;
                n_dcnt = '0;
                n_phase = nbcg_pkg::PH_ID_DATA;
            end
            nbcg_pkg::PH_ID_DATA: begin
                if (re) begin
                    if (r_dcnt < CW'(ID_MAX)) begin
                        o_res[0] = nbcg_pkg::f_byte(nbcg_pkg::EV_READ_ID, nbcg_pkg::PT_DATA,
                                                    i_cycle, i_stamp, 14'(r_dcnt));
                        n_dcnt = dinc;
                        hw_en = 1'b1;
                        hw_idx = 3'd6;
                    end else begin
                        n_phase = nbcg_pkg::PH_IDLE;
                        o_res[0] = nbcg_pkg::f_end(nbcg_pkg::EV_READ_ID, 14'(r_dcnt),
                                                   i_cycle, i_stamp);
                    end
                    n = 4'd1;
                end else begin
                    o_res[0] = nbcg_pkg::f_end(nbcg_pkg::EV_READ_ID, 14'(r_dcnt),
                                               r_hcyc[6], r_htim[6]);
                    n = 4'd1;
                    do_idle = 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
            n_phase = nbcg_pkg::PH_IDLE;
            if (!i_cycle[8] || ncode == nbcg_pkg::EV_UNKNOWN) begin
                o_res[n[2:0]] = nbcg_pkg::f_raw(i_cycle, i_stamp, 1'b1);
                n = n + 4'd1;
            end else if (ncode == nbcg_pkg::EV_READ_ID) begin
                n_phase = nbcg_pkg::PH_ID_ADDR;
                n_pend = nbcg_pkg::EV_READ_ID;
                o_res[n[2:0]] = nbcg_pkg::f_start(ncode, i_cycle, i_stamp);
                n = n + 4'd1;
            end else if (ncode >= nbcg_pkg::EV_CACHE_30) begin
                o_res[n[2:0]] = nbcg_pkg::f_start(ncode, i_cycle, i_stamp);
                o_res[3'(n + 4'd1)] = nbcg_pkg::f_end(ncode, 14'd0, i_cycle, i_stamp);
                n = n + 4'd2;
            end else begin
                n_pend = ncode;
                hw_en = 1'b1;
                hw_idx = 3'd0;
                n_step = 3'd1;
                n_phase = nbcg_pkg::PH_SHAPE;
            end
        end
        o_cnt = n;
    end

endmodule
`default_nettype wire

@@ sv/nbcg_emit.sv @@
// result buffer and output register, one result per transaction
`default_nettype none
`include "nand_bus_cycle_grouper_unit_macros.svh"
module nbcg_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  nbcg_pkg::t_res      i_res [nbcg_pkg::MAX_RES],
    input  wire logic [3:0]     i_cnt,
    output logic                o_space,
    output logic                o_valid,
    input  wire logic           i_ready,
    output nbcg_pkg::t_res      o_res
);
    nbcg_pkg::t_res r_buf [nbcg_pkg::MAX_RES];
    nbcg_pkg::t_res r_out;
    logic [3:0]     r_rem;
    logic           r_ov;
    logic           move;

    assign move = (r_rem != 4'd0) && (!r_ov || i_ready);
    assign o_space = (r_rem == 4'd0) || ((r_rem == 4'd1) && move);
    assign o_valid = r_ov;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 4'd0;
            r_ov <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_load) begin
                r_rem <= i_cnt;
            end else if (move) begin
                r_rem <= r_rem - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_buf[0];
        end
        if (i_load) begin
            r_buf <= i_res;
        end else if (move) begin
            for (int i = 0; i < nbcg_pkg::MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    `NBCG_ASSERT(a_rem_range, r_rem <= 4'd8)
    `NBCG_ASSERT(a_load_cnt, !i_load || i_cnt <= 4'd8)
    `NBCG_ASSERT_IMP(a_move_fills, move, r_ov)
    `NBCG_ASSERT_IMP(a_load_only_free, i_load && !move, r_rem == $past(i_cnt))

endmodule
`default_nettype wire

@@ sv/nand_bus_cycle_grouper_unit.sv @@
// top level of the nand bus cycle grouper
// input stream: one captured nand bus cycle per transaction on the s side
// (byte, cle, ale, we, re, aux, seconds, nanoseconds in tdata)
// output stream: command events as start, address, data, end and raw results
// on the m side; tlast marks the final result of each event or raw run,
// tuser carries the event code and the part
// every cycle is decoded in the cycle it is taken and gives zero to seven
// results, which enter a result buffer and from there the output register
// the output drains one result per cycle while the m side is ready; a new
// cycle is taken once the buffer holds at most one result that leaves in
// the same cycle, so single-result cycles flow at one per clock while the
// m side is ready
// reset returns the decoder to idle and empties the buffer and the output
// when the m side stalls the output register holds its result and the s
// side is held off while any result waits in the buffer
`default_nettype none
module nand_bus_cycle_grouper_unit #(
    parameter int ID_MAX = 8,
    parameter int DATA_MAX = 8192
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // bus_byte, cmd_latch, addr_latch, write_strobe, read_strobe, aux_bits,
    // stamp_sec, stamp_nsec, zero fill
    input  wire logic [87:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // byte_value, byte_index, control_bits, aux_out, time_sec, time_nsec
    output logic [95:0]      o_m_tdata,
    // event_code, part
    output logic [6:0]       o_m_tuser,
    output logic             o_m_tlast
);
    logic           accept;
    logic [19:0]    cycle;
    logic [61:0]    stamp;
    nbcg_pkg::t_res dec_res [nbcg_pkg::MAX_RES];
    logic [3:0]     dec_cnt;
    nbcg_pkg::t_res out_res;

    assign accept = i_s_tvalid && o_s_tready;
    assign cycle = i_s_tdata[19:0];
    assign stamp = {i_s_tdata[51:20], i_s_tdata[81:52]};

    nbcg_ctrl #(
        .ID_MAX(ID_MAX),
        .DATA_MAX(DATA_MAX)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_cycle(cycle),
        .i_stamp(stamp),
        .o_res(dec_res),
        .o_cnt(dec_cnt)
    );

    nbcg_emit u_emit (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_load(accept),
        .i_res(dec_res),
        .i_cnt(dec_cnt),
        .o_space(o_s_tready),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_res(out_res)
    );

    assign o_m_tdata = {out_res.stamp[29:0], out_res.stamp[61:30], out_res.aux,
                        out_res.ctl, out_res.byte_index, out_res.byte_value};
    assign o_m_tuser = {out_res.part, out_res.code};
    assign o_m_tlast = out_res.last;

endmodule
`default_nettype wire
